### rtl/cafl_pkg.sv
// Package for the add-and-flags execution unit: port item types, command codes,
// decoded operation type and flag bit positions. No dependencies.
`timescale 1ns / 1ps

package cafl_pkg;

  // Command codes carried on the input channel
  typedef enum logic [2:0] {
    CMD_ADC_A   = 3'd0,
    CMD_ADD_A   = 3'd1,
    CMD_AND_A   = 3'd2,
    CMD_ADD_HL  = 3'd3,
    CMD_ADD_HSP = 3'd4,
    CMD_ADD_SP  = 3'd5
  } cmd_t;

  // Operation class after decode
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADD8  = 3'd1,
    OP_AND8  = 3'd2,
    OP_ADDHL = 3'd3,
    OP_ADDSP = 3'd4
  } op_kind_t;

  // Flag bit positions in the flag nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Input request
  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        data_byte;
    logic [15:0]       data_word;
    logic signed [7:0] offset;
  } in_item_t;

  // Result: register state after the operation
  typedef struct packed {
    logic [7:0]  acc_out;
    logic [3:0]  flags_out;
    logic [15:0] hl_out;
    logic [15:0] sp_out;
  } out_item_t;

  // Decoded operation passed from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic        use_carry;
    logic        hl_from_sp;
    logic [7:0]  data_byte;
    logic [15:0] data_word;
    logic [7:0]  offset;
  } op_t;

endpackage

### rtl/cafl_front.sv
// Front stage: accepts input requests and decodes the command into an operation class.
// Depends on cafl_pkg.
`timescale 1ns / 1ps

module cafl_front
  import cafl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  logic     q_ready,
  output logic     q_push,
  output op_t      q_op
);

  logic f_v_r, f_v_nxt;
  op_t  f_op_r, f_op_nxt;
  logic f_load;

  // Decode the incoming command
  always_comb begin
    f_op_nxt            = '0;
    f_op_nxt.data_byte  = in_data.data_byte;
    f_op_nxt.data_word  = in_data.data_word;
    f_op_nxt.offset     = in_data.offset;
    f_op_nxt.kind       = OP_NONE;
    f_op_nxt.use_carry  = 1'b0;
    f_op_nxt.hl_from_sp = 1'b0;
    case (cmd_t'(in_data.cmd))
      CMD_ADC_A: begin
        f_op_nxt.kind      = OP_ADD8;
        f_op_nxt.use_carry = 1'b1;
      end
      CMD_ADD_A:  f_op_nxt.kind = OP_ADD8;
      CMD_AND_A:  f_op_nxt.kind = OP_AND8;
      CMD_ADD_HL: f_op_nxt.kind = OP_ADDHL;
      CMD_ADD_HSP: begin
        f_op_nxt.kind       = OP_ADDHL;
        f_op_nxt.hl_from_sp = 1'b1;
      end
      CMD_ADD_SP: f_op_nxt.kind = OP_ADDSP;
      default:    f_op_nxt.kind = OP_NONE;
    endcase
  end

  // Hold the stage while the queue cannot take it
  assign in_full = f_v_r && !q_ready;
  assign f_load  = in_push && !in_full;
  assign q_push  = f_v_r && q_ready;
  assign q_op    = f_op_r;

  always_comb begin
    f_v_nxt = f_v_r;
    if (f_load) begin
      f_v_nxt = 1'b1;
    end else if (q_push) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_op_r <= f_op_nxt;
    end
  end

endmodule

### rtl/cafl_queue.sv
// Two-entry queue of decoded operations between front and back.
// Depends on cafl_pkg.
`timescale 1ns / 1ps

module cafl_queue
  import cafl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic ready,
  input  logic pop,
  output logic valid,
  output op_t  head_op
);

  localparam int unsigned Depth = 2;

  op_t        ent_r [Depth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign ready   = (count_r != 2'(Depth));
  assign valid   = (count_r != 2'd0);
  assign head_op = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(Depth))
    else $error("queue occupancy beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !ready))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid))
    else $error("pop from an empty queue");

endmodule

### rtl/cafl_back.sv
// Back stage: executes decoded operations on A, flags, HL and SP and holds the result.
// Depends on cafl_pkg.
`timescale 1ns / 1ps

module cafl_back
  import cafl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic [7:0]  acc_r, acc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] hl_r, hl_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic        out_v_r, out_v_nxt;

  logic        cin;
  logic [8:0]  sum8;
  logic [4:0]  nib8;
  logic [7:0]  and8;
  logic [15:0] hl_opnd;
  logic [16:0] sum16;
  logic [12:0] low12;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_byte;
  logic        fire;

  // Take the next operation once the result slot is free or being drained
  assign fire  = q_valid && (!out_v_r || out_pop);
  assign q_pop = fire;

  // Datapath for every operation class
  always_comb begin
    cin     = q_op.use_carry & flags_r[FLAG_C];
    sum8    = {1'b0, acc_r} + {1'b0, q_op.data_byte} + {8'd0, cin};
    nib8    = {1'b0, acc_r[3:0]} + {1'b0, q_op.data_byte[3:0]} + {4'd0, cin};
    and8    = acc_r & q_op.data_byte;
    hl_opnd = q_op.hl_from_sp ? sp_r : q_op.data_word;
    sum16   = {1'b0, hl_r} + {1'b0, hl_opnd};
    low12   = {1'b0, hl_r[11:0]} + {1'b0, hl_opnd[11:0]};
    sp_sum  = sp_r + {{8{q_op.offset[7]}}, q_op.offset};
    sp_nib  = {1'b0, sp_r[3:0]} + {1'b0, q_op.offset[3:0]};
    sp_byte = {1'b0, sp_r[7:0]} + {1'b0, q_op.offset};
  end

  // Select the new register state
  always_comb begin
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    hl_nxt    = hl_r;
    sp_nxt    = sp_r;
    if (fire) begin
      case (q_op.kind)
        OP_ADD8: begin
          acc_nxt   = sum8[7:0];
          flags_nxt = {(sum8[7:0] == 8'd0), 1'b0, nib8[4], sum8[8]};
        end
        OP_AND8: begin
          acc_nxt   = and8;
          flags_nxt = {(and8 == 8'd0), 1'b0, 1'b1, 1'b0};
        end
        OP_ADDHL: begin
          hl_nxt    = sum16[15:0];
          flags_nxt = {flags_r[FLAG_Z], 1'b0, low12[12], sum16[16]};
        end
        OP_ADDSP: begin
          sp_nxt    = sp_sum;
          flags_nxt = {1'b0, 1'b0, sp_nib[4], sp_byte[8]};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  // Result slot: full after an operation, empty once drained
  always_comb begin
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      flags_r <= 4'd0;
      hl_r    <= 16'd0;
      sp_r    <= 16'd0;
      out_v_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
      hl_r    <= hl_nxt;
      sp_r    <= sp_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // The result is the register state itself
  assign out_empty          = !out_v_r;
  assign out_data.acc_out   = acc_r;
  assign out_data.flags_out = flags_r;
  assign out_data.hl_out    = hl_r;
  assign out_data.sp_out    = sp_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("executed operation left no result");

  a_state_held_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_pop) |=> ($stable(acc_r) && $stable(flags_r)
                              && $stable(hl_r) && $stable(sp_r)))
    else $error("register state changed under an undelivered result");

  a_and_sets_h: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && q_op.kind == OP_AND8) |=> (flags_r[FLAG_H] && !flags_r[FLAG_C]))
    else $error("AND flags wrong");

endmodule

### rtl/cpu_alu_add_and_flags_top.sv
// Add-and-flags execution unit, top level. A request is registered in the front, written
// into the queue, then executed in the back, whose registers present the result.
// Throughput: one request per cycle while results are popped; a stalled out_pop holds back
// new requests.
// Reset (synchronous, active low) clears A, flags, HL, SP and empties every stage.
// Depends on cafl_pkg, cafl_front, cafl_queue and cafl_back.
`timescale 1ns / 1ps

module cpu_alu_add_and_flags_top
  import cafl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic q_push, q_ready, q_pop, q_valid;
  op_t  q_in_op, q_head_op;

  // Accept and decode
  cafl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_op    (q_in_op)
  );

  // Decouple front from back
  cafl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (q_head_op)
  );

  // Execute and present results
  cafl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_head_op),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### dv/tb_top.sv
// Self-checking testbench for cpu_alu_add_and_flags_top: directed table then random requests, every result
// checked against the table's expected value where given, else an in-bench model of A, flags, HL and SP.
// Depends on cafl_pkg and the RTL of cpu_alu_add_and_flags_top.
`timescale 1ns / 1ps

module tb_top;
  import cafl_pkg::*;

  // Command codes the package leaves unnamed; the block must treat them as no-ops
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int unsigned TOTAL_REQUESTS = 1950;
  localparam int unsigned CALM_TAIL      = 150;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t want;
  } table_row_t;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_push  = 1'b0;
  logic      out_pop  = 1'b0;
  in_item_t  in_data  = '0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;

  // Typed expectation travelling alongside the request on the input side
  bit        row_known = 1'b0;
  out_item_t row_want  = '0;

  // Model state
  logic [7:0]  a_reg  = '0;
  logic [3:0]  f_reg  = '0;
  logic [15:0] hl_reg = '0;
  logic [15:0] sp_reg = '0;

  out_item_t   pending_results[$];
  table_row_t  directed_rows[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  bit          calm        = 1'b0;

  cpu_alu_add_and_flags_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run one operation on the model state and return the register snapshot
  function automatic out_item_t execute_op(input in_item_t req);
    logic [4:0]  nib;
    logic [8:0]  sum8;
    logic [12:0] sum12;
    logic [16:0] sum16;
    logic [15:0] addend;
    logic [7:0]  off_bits;
    logic        cin;
    out_item_t   res;
    off_bits = req.offset;
    case (req.cmd)
      CMD_ADC_A, CMD_ADD_A: begin
        cin   = (req.cmd == CMD_ADC_A) ? f_reg[FLAG_C] : 1'b0;
        nib   = {1'b0, a_reg[3:0]} + {1'b0, req.data_byte[3:0]} + {4'd0, cin};
        sum8  = {1'b0, a_reg} + {1'b0, req.data_byte} + {8'd0, cin};
        a_reg = sum8[7:0];
        f_reg = {sum8[7:0] == 8'h00, 1'b0, nib[4], sum8[8]};
      end
      CMD_AND_A: begin
        a_reg = a_reg & req.data_byte;
        f_reg = {a_reg == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      CMD_ADD_HL, CMD_ADD_HSP: begin
        addend = (req.cmd == CMD_ADD_HL) ? req.data_word : sp_reg;
        sum12  = {1'b0, hl_reg[11:0]} + {1'b0, addend[11:0]};
        sum16  = {1'b0, hl_reg} + {1'b0, addend};
        // zero flag survives a word add
        f_reg  = {f_reg[FLAG_Z], 1'b0, sum12[12], sum16[16]};
        hl_reg = sum16[15:0];
      end
      CMD_ADD_SP: begin
        // carries come from the unsigned low byte, the sum from the sign-extended one
        nib    = {1'b0, sp_reg[3:0]} + {1'b0, off_bits[3:0]};
        sum8   = {1'b0, sp_reg[7:0]} + {1'b0, off_bits};
        sp_reg = sp_reg + {{8{off_bits[7]}}, off_bits};
        f_reg  = {1'b0, 1'b0, nib[4], sum8[8]};
      end
      default: begin
      end
    endcase
    res.acc_out   = a_reg;
    res.flags_out = f_reg;
    res.hl_out    = hl_reg;
    res.sp_out    = sp_reg;
    return res;
  endfunction

  // Pick a byte with a lean towards the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    if ($urandom_range(0, 99) < 5)
      req.cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    else
      req.cmd = 3'($urandom_range(0, 5));
    req.data_byte = pick_byte();
    req.data_word = ($urandom_range(0, 3) == 0) ? {pick_byte(), pick_byte()} : 16'($urandom);
    req.offset    = pick_byte();
    return req;
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] data_byte,
                         input logic [15:0] data_word, input logic [7:0] offset,
                         input bit known, input out_item_t want);
    table_row_t row;
    row.req.cmd       = cmd;
    row.req.data_byte = data_byte;
    row.req.data_word = data_word;
    row.req.offset    = offset;
    row.known         = known;
    row.want          = want;
    directed_rows.push_back(row);
  endtask

  // Present one request and hold it until the block takes it
  task automatic send_request(input in_item_t req, input bit known, input out_item_t want);
    in_data   <= req;
    row_known <= known;
    row_want  <= want;
    in_push   <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Maybe drop push for a short burst after a request
  task automatic sender_gap();
    int unsigned n;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      n = $urandom_range(1, 3);
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Result side: pop with random stall bursts
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        stall--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predicted = execute_op(in_data);
        pending_results.push_back(row_known ? row_want : predicted);
      end
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: acc %h flags %h hl %h sp %h",
                     out_data.acc_out, out_data.flags_out, out_data.hl_out, out_data.sp_out);
        end else begin
          want = pending_results.pop_front();
          if (out_data.acc_out !== want.acc_out || out_data.flags_out !== want.flags_out ||
              out_data.hl_out !== want.hl_out || out_data.sp_out !== want.sp_out) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp acc %h flags %h hl %h sp %h, got acc %h flags %h hl %h sp %h",
                       want.acc_out, want.flags_out, want.hl_out, want.sp_out,
                       out_data.acc_out, out_data.flags_out, out_data.hl_out, out_data.sp_out);
          end
        end
      end
    end
  end

  // Give up on a hung block
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned n_random;
    int unsigned i;
    // from reset: zero sum, plain byte, carry out of both nibble and byte, AND sets H
    add_row(CMD_ADD_A,   8'h00, 16'hFFFF, 8'hFF, 1'b1, '{8'h00, 4'h8, 16'h0000, 16'h0000});
    add_row(CMD_ADD_A,   8'hFF, 16'hFFFF, 8'h7F, 1'b1, '{8'hFF, 4'h0, 16'h0000, 16'h0000});
    add_row(CMD_ADC_A,   8'h01, 16'h0000, 8'h80, 1'b1, '{8'h00, 4'hB, 16'h0000, 16'h0000});
    add_row(CMD_ADC_A,   8'hFF, 16'h0000, 8'h00, 1'b1, '{8'h00, 4'hB, 16'h0000, 16'h0000});
    add_row(CMD_AND_A,   8'hFF, 16'hFFFF, 8'hFF, 1'b1, '{8'h00, 4'hA, 16'h0000, 16'h0000});
    // half carry alone, AND to zero, byte carry to zero, carry-in used
    add_row(CMD_ADD_A,   8'h0F, 16'h1234, 8'h01, 1'b0, '0);
    add_row(CMD_ADC_A,   8'h01, 16'h0000, 8'h00, 1'b0, '0);
    add_row(CMD_AND_A,   8'hA5, 16'h0000, 8'h00, 1'b0, '0);
    add_row(CMD_ADD_A,   8'h80, 16'h0000, 8'h00, 1'b0, '0);
    add_row(CMD_ADD_A,   8'h80, 16'h0000, 8'h00, 1'b0, '0);
    add_row(CMD_ADC_A,   8'h7F, 16'h0000, 8'h00, 1'b0, '0);
    // word adds into HL: top extreme, wrap with both carries, low twelve bits all ones without a bit-11 carry
    add_row(CMD_ADD_HL,  8'hFF, 16'hFFFF, 8'h80, 1'b0, '0);
    add_row(CMD_ADD_HL,  8'h00, 16'h0001, 8'h7F, 1'b0, '0);
    add_row(CMD_ADD_HL,  8'h00, 16'h0FFF, 8'h00, 1'b0, '0);
    // signed offsets to SP: both extremes, wrap upward and downward
    add_row(CMD_ADD_SP,  8'hFF, 16'hFFFF, 8'h80, 1'b0, '0);
    add_row(CMD_ADD_SP,  8'h00, 16'h0000, 8'h7F, 1'b0, '0);
    add_row(CMD_ADD_SP,  8'h00, 16'h0000, 8'h01, 1'b0, '0);
    add_row(CMD_ADD_SP,  8'h00, 16'h0000, 8'hFF, 1'b0, '0);
    add_row(CMD_ADD_SP,  8'h00, 16'h0000, 8'h0F, 1'b0, '0);
    // HL += SP
    add_row(CMD_ADD_HSP, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, '0);
    add_row(CMD_ADD_HSP, 8'h00, 16'h0000, 8'h00, 1'b0, '0);
    // unused codes change nothing
    add_row(CMD_RSVD6,   8'hFF, 16'hFFFF, 8'hFF, 1'b0, '0);
    add_row(CMD_RSVD7,   8'hFF, 16'hFFFF, 8'h80, 1'b0, '0);

    // Hold reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].want);
      sender_gap();
    end

    n_random = TOTAL_REQUESTS - directed_rows.size();
    for (i = 0; i < n_random; i++) begin
      // vary idling per window, some windows with none
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      calm = (i + CALM_TAIL >= n_random);
      // drain the block once mid-run
      if (i == n_random / 2) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_request(random_request(), 1'b0, '0);
      sender_gap();
    end

    // Wait for every result, then let the pipeline settle
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
